// ----- rtl/cache_mask_register_virtualizer_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cache mask register virtualizer
// ----------------------------------------------------------------------------
`ifndef CACHE_MASK_REGISTER_VIRTUALIZER_CORE_MACROS_SVH
`define CACHE_MASK_REGISTER_VIRTUALIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CMRV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cmrv assertion failed");

// Next-cycle implication, disabled during reset.
`define CMRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cmrv assertion failed");

`endif

// ----- rtl/cmrv_pkg.sv -----
// ----------------------------------------------------------------------------
// cmrv_pkg
// Types, codes and helper functions shared by the virtualizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cmrv_pkg;

    localparam int MASK_W_MAX = 32;
    localparam int CFG_IDX_W  = 4;

    // Request kinds
    localparam logic [1:0] KIND_RD_MASK  = 2'd0;
    localparam logic [1:0] KIND_WR_MASK  = 2'd1;
    localparam logic [1:0] KIND_RD_CLASS = 2'd2;
    localparam logic [1:0] KIND_WR_CLASS = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VCAT_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_ENABLE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_ENABLE   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAY_MASK = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_WAY_MASK = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_MAP   = 4'd6;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_DENIED = 1'b1;

    typedef struct packed {
        logic        vcat_enable;
        logic        l2_enable;
        logic        l3_enable;
        logic [3:0]  class_count;
        logic [31:0] l2_way_mask;
        logic [31:0] l3_way_mask;
        logic [63:0] class_map;
    } cfg_t;

    typedef struct packed {
        logic                  l2_we;
        logic                  l3_we;
        logic                  cls_we;
        logic [2:0]            idx;
        logic [MASK_W_MAX-1:0] mask_data;
        logic [63:0]           cls_data;
    } wr_t;

    typedef struct packed {
        logic        status;
        logic [63:0] read_data;
        logic        phys_mask_write;
        logic        phys_class_update;
        logic [7:0]  phys_class;
        logic        phys_level;
        logic [31:0] phys_bits;
        logic [31:0] phys_bit_enable;
    } res_t;

    // Index of the lowest set bit, zero for an empty word.
    function automatic logic [4:0] lowest_index(input logic [31:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    // Byte v of the packed class map.
    function automatic logic [7:0] map_class(input logic [63:0] map, input logic [2:0] v);
        logic [63:0] sh;
        sh = map >> {v, 3'b000};
        return sh[7:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cmrv_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cmrv_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrv_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cmrv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    output cmrv_pkg::cfg_t                     cfg
);

    cmrv_pkg::cfg_t cfg_reg;
    cmrv_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                cmrv_pkg::CFG_VCAT_ENABLE: cfg_next.vcat_enable = cfg_data[0];
                cmrv_pkg::CFG_L2_ENABLE:   cfg_next.l2_enable   = cfg_data[0];
                cmrv_pkg::CFG_L3_ENABLE:   cfg_next.l3_enable   = cfg_data[0];
                cmrv_pkg::CFG_CLASS_COUNT: cfg_next.class_count = cfg_data[3:0];
                cmrv_pkg::CFG_L2_WAY_MASK: cfg_next.l2_way_mask = cfg_data[31:0];
                cmrv_pkg::CFG_L3_WAY_MASK: cfg_next.l3_way_mask = cfg_data[31:0];
                cmrv_pkg::CFG_CLASS_MAP:   cfg_next.class_map   = cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cmrv_vstore.sv -----
// ----------------------------------------------------------------------------
// cmrv_vstore
// Virtual L2/L3 mask registers and the virtual class-association register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrv_vstore #(
    parameter int MAX_CLASSES = 8,
    parameter int MASK_WIDTH  = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  commit,
    input  cmrv_pkg::wr_t              wr,
    input  wire logic [2:0]            rd_idx,
    output logic [MASK_WIDTH-1:0]      l2_rd,
    output logic [MASK_WIDTH-1:0]      l3_rd,
    output logic [63:0]                cls_rd
);

    localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    logic [MASK_WIDTH-1:0] l2_mask_reg [MAX_CLASSES];
    logic [MASK_WIDTH-1:0] l3_mask_reg [MAX_CLASSES];
    logic [63:0]           cls_sel_reg;

    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_sel;

    assign wr_idx = wr.idx[IDX_W-1:0];
    assign rd_sel = rd_idx[IDX_W-1:0];

    assign l2_rd  = l2_mask_reg[rd_sel];
    assign l3_rd  = l3_mask_reg[rd_sel];
    assign cls_rd = cls_sel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                l2_mask_reg[i] <= '0;
                l3_mask_reg[i] <= '0;
            end
            cls_sel_reg <= '0;
        end else if (commit) begin
            if (wr.l2_we) begin
                l2_mask_reg[wr_idx] <= wr.mask_data[MASK_WIDTH-1:0];
            end
            if (wr.l3_we) begin
                l3_mask_reg[wr_idx] <= wr.mask_data[MASK_WIDTH-1:0];
            end
            if (wr.cls_we) begin
                cls_sel_reg <= wr.cls_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cmrv_decide.sv -----
// ----------------------------------------------------------------------------
// cmrv_decide
// Access checks and result forming for one registered request.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrv_decide #(
    parameter int MAX_CLASSES = 8,
    parameter int MASK_WIDTH  = 32
) (
    input  cmrv_pkg::cfg_t             cfg,
    input  wire logic [1:0]            kind,
    input  wire logic                  cache_level,
    input  wire logic [7:0]            reg_offset,
    input  wire logic [63:0]           write_value,
    input  wire logic [MASK_WIDTH-1:0] l2_rd,
    input  wire logic [MASK_WIDTH-1:0] l3_rd,
    input  wire logic [63:0]           cls_rd,
    output logic [2:0]                 rd_idx,
    output cmrv_pkg::wr_t              wr,
    output cmrv_pkg::res_t             res
);

    localparam logic [31:0] WAY_LIMIT = 32'((64'd1 << MASK_WIDTH) - 64'd1);
    localparam logic [3:0]  MAX_CNT   = 4'(MAX_CLASSES);

    logic [3:0]  eff_count;
    logic        lvl_en;
    logic [31:0] way;
    logic [4:0]  low;
    logic [31:0] vmax;
    logic        mask_ok;
    logic        fits;
    logic [31:0] fill;
    logic        one_run;
    logic [63:0] mask_rd;
    logic        cls_ok;

    assign rd_idx = reg_offset[2:0];

    always_comb begin
        eff_count = (cfg.class_count > MAX_CNT) ? MAX_CNT : cfg.class_count;
        lvl_en    = cache_level ? cfg.l3_enable : cfg.l2_enable;
        way       = (cache_level ? cfg.l3_way_mask : cfg.l2_way_mask) & WAY_LIMIT;
        low       = cmrv_pkg::lowest_index(way);
        vmax      = way >> low;
        mask_ok   = cfg.vcat_enable && lvl_en && (reg_offset < {4'd0, eff_count});
        fits      = (write_value[63:32] == 32'd0) && ((write_value[31:0] & ~vmax) == 32'd0);
        // fill the trailing zeros; a single run then becomes 2^k - 1
        fill      = write_value[31:0] | (write_value[31:0] - 32'd1);
        one_run   = (write_value[31:0] != 32'd0) && ((fill & (fill + 32'd1)) == 32'd0);
        mask_rd   = cache_level ? 64'(l3_rd) : 64'(l2_rd);
        cls_ok    = cfg.vcat_enable && (write_value[31:0] == 32'd0) &&
                    (write_value[63:32] < {28'd0, eff_count});

        res           = '0;
        res.status    = cmrv_pkg::STATUS_DENIED;
        wr            = '0;
        wr.idx        = reg_offset[2:0];
        wr.mask_data  = write_value[31:0];
        wr.cls_data   = write_value;

        case (kind)
            cmrv_pkg::KIND_RD_MASK: begin
                if (mask_ok) begin
                    res.status    = cmrv_pkg::STATUS_OK;
                    res.read_data = mask_rd;
                end
            end
            cmrv_pkg::KIND_WR_MASK: begin
                if (mask_ok && fits && one_run) begin
                    res.status          = cmrv_pkg::STATUS_OK;
                    res.phys_mask_write = 1'b1;
                    res.phys_class      = cmrv_pkg::map_class(cfg.class_map, reg_offset[2:0]);
                    res.phys_level      = cache_level;
                    res.phys_bits       = write_value[31:0] << low;
                    res.phys_bit_enable = way;
                    wr.l2_we            = !cache_level;
                    wr.l3_we            = cache_level;
                end
            end
            cmrv_pkg::KIND_RD_CLASS: begin
                if (cfg.vcat_enable) begin
                    res.status    = cmrv_pkg::STATUS_OK;
                    res.read_data = cls_rd;
                end
            end
            cmrv_pkg::KIND_WR_CLASS: begin
                if (cls_ok) begin
                    res.status            = cmrv_pkg::STATUS_OK;
                    res.phys_class_update = 1'b1;
                    res.phys_class        = cmrv_pkg::map_class(cfg.class_map,
                                                                write_value[34:32]);
                    wr.cls_we             = 1'b1;
                end
            end
            default: begin
                res.status = cmrv_pkg::STATUS_DENIED;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/cache_mask_register_virtualizer_core.sv -----
// ----------------------------------------------------------------------------
// cache_mask_register_virtualizer_core: guest cache-allocation register virtualizer
// Checks mask and class-select requests, keeps virtual copies, asks for physical updates.
// Two registers in line (input register, then result register); one request per cycle.
// Rate set by the single check pass between the two registers; m_ready low holds both.
// Reset (aresetn low, synchronous): config, virtual masks and class select clear to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cache_mask_register_virtualizer_core_macros.svh"

module cache_mask_register_virtualizer_core #(
    parameter int MAX_CLASSES = 8,
    parameter int MASK_WIDTH  = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [cmrv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_data,

    // request channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_kind,
    input  wire logic                           s_cache_level,
    input  wire logic [7:0]                     s_reg_offset,
    input  wire logic [63:0]                    s_write_value,

    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_status,
    output logic [63:0]                         m_read_data,
    output logic                                m_phys_mask_write,
    output logic                                m_phys_class_update,
    output logic [7:0]                          m_phys_class,
    output logic                                m_phys_level,
    output logic [31:0]                         m_phys_bits,
    output logic [31:0]                         m_phys_bit_enable
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cmrv_pkg::cfg_t cfg;

    cmrv_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Input register: one request waits here for its check pass.
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  kind_reg;
    logic        level_reg;
    logic [7:0]  offset_reg;
    logic [63:0] value_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    cmrv_pkg::res_t res_reg;

    // Advance whenever the result register is empty or being drained.
    logic advance;
    logic commit;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    // Commit the store update exactly when the request moves to the result register,
    // so the next request already sees it.
    assign commit  = advance && in_valid_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on accept, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg   <= s_kind;
            level_reg  <= s_cache_level;
            offset_reg <= s_reg_offset;
            value_reg  <= s_write_value;
        end
    end

    // ------------------------------------------------------------------
    // Virtual register store and the check pass
    // ------------------------------------------------------------------
    logic [2:0]            rd_idx;
    logic [MASK_WIDTH-1:0] l2_rd;
    logic [MASK_WIDTH-1:0] l3_rd;
    logic [63:0]           cls_rd;
    cmrv_pkg::wr_t         wr;
    cmrv_pkg::res_t        res;

    cmrv_vstore #(
        .MAX_CLASSES (MAX_CLASSES),
        .MASK_WIDTH  (MASK_WIDTH)
    ) u_vstore (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (commit),
        .wr      (wr),
        .rd_idx  (rd_idx),
        .l2_rd   (l2_rd),
        .l3_rd   (l3_rd),
        .cls_rd  (cls_rd)
    );

    cmrv_decide #(
        .MAX_CLASSES (MAX_CLASSES),
        .MASK_WIDTH  (MASK_WIDTH)
    ) u_decide (
        .cfg         (cfg),
        .kind        (kind_reg),
        .cache_level (level_reg),
        .reg_offset  (offset_reg),
        .write_value (value_reg),
        .l2_rd       (l2_rd),
        .l3_rd       (l3_rd),
        .cls_rd      (cls_rd),
        .rd_idx      (rd_idx),
        .wr          (wr),
        .res         (res)
    );

    // ------------------------------------------------------------------
    // Result register: hold the result until the request is taken.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (commit) begin
            res_reg <= res;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_status            = res_reg.status;
    assign m_read_data         = res_reg.read_data;
    assign m_phys_mask_write   = res_reg.phys_mask_write;
    assign m_phys_class_update = res_reg.phys_class_update;
    assign m_phys_class        = res_reg.phys_class;
    assign m_phys_level        = res_reg.phys_level;
    assign m_phys_bits         = res_reg.phys_bits;
    assign m_phys_bit_enable   = res_reg.phys_bit_enable;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CMRV_ASSERT_NEXT(a_commit_fills_output, aclk, aresetn, commit, out_valid_reg)

    `CMRV_ASSERT_NOW(a_update_kinds_exclusive, aclk, aresetn,
        out_valid_reg && res_reg.phys_mask_write,
        !res_reg.phys_class_update && (res_reg.status == cmrv_pkg::STATUS_OK))

    `CMRV_ASSERT_NOW(a_denied_is_quiet, aclk, aresetn,
        out_valid_reg && (res_reg.status == cmrv_pkg::STATUS_DENIED),
        (res_reg.read_data == 64'd0) && !res_reg.phys_mask_write && !res_reg.phys_class_update)

    `CMRV_ASSERT_NOW(a_bits_inside_enable, aclk, aresetn,
        out_valid_reg && res_reg.phys_mask_write,
        (res_reg.phys_bits & ~res_reg.phys_bit_enable) == 32'd0)

endmodule

`default_nettype wire

// ----- dv/tb_cache_mask_register_virtualizer_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cache_mask_register_virtualizer_core: self-checking bench for the virtualizer
// Programs the guest setup through the configuration channel and streams mask and
// class-select requests with random stalls on both sides. A shadow model keeps its
// own copy of the virtual registers, predicts every reply and checks it in order.
// ----------------------------------------------------------------------------

class virtualizer_shadow;
    localparam int unsigned CLASS_LIMIT = 8;

    bit        vcat_en;
    bit        l2_en;
    bit        l3_en;
    bit [3:0]  class_count;
    bit [31:0] l2_ways;
    bit [31:0] l3_ways;
    bit [63:0] class_map;

    bit [31:0] l2_vmask [8];
    bit [31:0] l3_vmask [8];
    bit [63:0] class_select;

    cmrv_pkg::res_t verdicts [$];
    int             errors;

    function void set_reg(logic [cmrv_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            cmrv_pkg::CFG_VCAT_ENABLE: vcat_en     = data[0];
            cmrv_pkg::CFG_L2_ENABLE:   l2_en       = data[0];
            cmrv_pkg::CFG_L3_ENABLE:   l3_en       = data[0];
            cmrv_pkg::CFG_CLASS_COUNT: class_count = data[3:0];
            cmrv_pkg::CFG_L2_WAY_MASK: l2_ways     = data[31:0];
            cmrv_pkg::CFG_L3_WAY_MASK: l3_ways     = data[31:0];
            cmrv_pkg::CFG_CLASS_MAP:   class_map   = data;
            default: ;
        endcase
    endfunction

    function int unsigned effective_classes();
        return (class_count > CLASS_LIMIT) ? CLASS_LIMIT : int'(class_count);
    endfunction

    function int unsigned lowest_one(bit [63:0] v);
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                return i;
            end
        end
        return 0;
    endfunction

    function bit single_run(bit [63:0] v);
        bit [63:0] s;
        if (v == 64'd0) begin
            return 1'b0;
        end
        s = v >> lowest_one(v);
        return (s & (s + 64'd1)) == 64'd0;
    endfunction

    // Assigned ways moved down to bit 0.
    function bit [31:0] virtual_limit(bit level);
        bit [31:0] ways;
        ways = level ? l3_ways : l2_ways;
        return ways >> lowest_one(64'(ways));
    endfunction

    function bit [7:0] phys_of(bit [2:0] vclass);
        return 8'(class_map >> (vclass * 8));
    endfunction

    function void note_request(bit [1:0] kind, bit level, bit [7:0] offset, bit [63:0] value);
        cmrv_pkg::res_t r;
        bit [31:0]      ways;
        bit             mask_ok;
        int unsigned    low;
        bit [31:0]      vclass;
        r        = '0;
        r.status = cmrv_pkg::STATUS_DENIED;
        ways     = level ? l3_ways : l2_ways;
        mask_ok  = vcat_en && (level ? l3_en : l2_en) && (offset < effective_classes());
        low      = lowest_one(64'(ways));
        vclass   = value[63:32];
        case (kind)
            cmrv_pkg::KIND_RD_MASK: begin
                if (mask_ok) begin
                    r.status    = cmrv_pkg::STATUS_OK;
                    r.read_data = 64'(level ? l3_vmask[offset[2:0]] : l2_vmask[offset[2:0]]);
                end
            end
            cmrv_pkg::KIND_WR_MASK: begin
                if (mask_ok && (value & ~64'(virtual_limit(level))) == 64'd0
                        && single_run(value)) begin
                    if (level) begin
                        l3_vmask[offset[2:0]] = value[31:0];
                    end else begin
                        l2_vmask[offset[2:0]] = value[31:0];
                    end
                    r.status          = cmrv_pkg::STATUS_OK;
                    r.phys_mask_write = 1'b1;
                    r.phys_class      = phys_of(offset[2:0]);
                    r.phys_level      = level;
                    r.phys_bits       = value[31:0] << low;
                    r.phys_bit_enable = ways;
                end
            end
            cmrv_pkg::KIND_RD_CLASS: begin
                if (vcat_en) begin
                    r.status    = cmrv_pkg::STATUS_OK;
                    r.read_data = class_select;
                end
            end
            default: begin
                if (vcat_en && value[31:0] == 32'd0 && vclass < effective_classes()) begin
                    class_select        = value;
                    r.status            = cmrv_pkg::STATUS_OK;
                    r.phys_class_update = 1'b1;
                    r.phys_class        = phys_of(vclass[2:0]);
                end
            end
        endcase
        verdicts.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_reply(cmrv_pkg::res_t got);
        cmrv_pkg::res_t want;
        if (verdicts.size() == 0) begin
            $display("%0t: reply with no request outstanding, actual %h", $time, got);
            errors++;
            return;
        end
        want = verdicts.pop_front();
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("phys_mask_write", 64'(want.phys_mask_write), 64'(got.phys_mask_write));
        compare_field("phys_class_update", 64'(want.phys_class_update),
                      64'(got.phys_class_update));
        compare_field("phys_class", 64'(want.phys_class), 64'(got.phys_class));
        compare_field("phys_level", 64'(want.phys_level), 64'(got.phys_level));
        compare_field("phys_bits", 64'(want.phys_bits), 64'(got.phys_bits));
        compare_field("phys_bit_enable", 64'(want.phys_bit_enable), 64'(got.phys_bit_enable));
    endfunction

    function int pending();
        return verdicts.size();
    endfunction
endclass

module tb_cache_mask_register_virtualizer_core;

    localparam int STALL_LIMIT   = 400;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 140;

    logic                           aclk;
    logic                           aresetn;

    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cmrv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [63:0]                    cfg_data;

    logic                           s_valid;
    logic                           s_ready;
    logic [1:0]                     s_kind;
    logic                           s_cache_level;
    logic [7:0]                     s_reg_offset;
    logic [63:0]                    s_write_value;

    logic                           m_valid;
    logic                           m_ready;
    logic                           m_status;
    logic [63:0]                    m_read_data;
    logic                           m_phys_mask_write;
    logic                           m_phys_class_update;
    logic [7:0]                     m_phys_class;
    logic                           m_phys_level;
    logic [31:0]                    m_phys_bits;
    logic [31:0]                    m_phys_bit_enable;

    // No stalls on either side once this is set.
    bit                             calm = 1'b0;

    virtualizer_shadow              shadow;

    cache_mask_register_virtualizer_core #(
        .MAX_CLASSES (8),
        .MASK_WIDTH  (32)
    ) dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_cache_level       (s_cache_level),
        .s_reg_offset        (s_reg_offset),
        .s_write_value       (s_write_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_read_data         (m_read_data),
        .m_phys_mask_write   (m_phys_mask_write),
        .m_phys_class_update (m_phys_class_update),
        .m_phys_class        (m_phys_class),
        .m_phys_level        (m_phys_level),
        .m_phys_bits         (m_phys_bits),
        .m_phys_bit_enable   (m_phys_bit_enable)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Write one configuration register; leave cfg_valid high so that a following
    // write can reuse it without a drop in the same step.
    task automatic write_cfg(logic [cmrv_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        shadow.set_reg(idx, data);
    endtask

    // Program the full guest setup, then drop the write channel.
    task automatic configure(bit vcat, bit l2, bit l3, bit [3:0] classes,
                             bit [31:0] l2_ways, bit [31:0] l3_ways, bit [63:0] cmap);
        write_cfg(cmrv_pkg::CFG_VCAT_ENABLE, 64'(vcat));
        write_cfg(cmrv_pkg::CFG_L2_ENABLE,   64'(l2));
        write_cfg(cmrv_pkg::CFG_L3_ENABLE,   64'(l3));
        write_cfg(cmrv_pkg::CFG_CLASS_COUNT, 64'(classes));
        write_cfg(cmrv_pkg::CFG_L2_WAY_MASK, 64'(l2_ways));
        write_cfg(cmrv_pkg::CFG_L3_WAY_MASK, 64'(l3_ways));
        write_cfg(cmrv_pkg::CFG_CLASS_MAP,   cmap);
        cfg_valid <= 1'b0;
    endtask

    // Present one request, hold it until accepted, then maybe idle for a burst.
    task automatic send_request(bit [1:0] kind, bit level, bit [7:0] offset, bit [63:0] value);
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_cache_level <= level;
        s_reg_offset  <= offset;
        s_write_value <= value;
        do @(posedge aclk); while (!s_ready);
        shadow.note_request(kind, level, offset, value);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    // Hold off until every outstanding reply has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
    endtask

    function automatic bit [31:0] pick_way_mask();
        int unsigned len;
        int unsigned start;
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: begin
                len   = $urandom_range(1, 32);
                start = $urandom_range(0, 32 - len);
                return 32'((64'd1 << len) - 64'd1) << start;
            end
        endcase
    endfunction

    // Mostly well-formed requests: offsets in range, masks that are a single run
    // inside the virtual limit, class writes with a clear low word. The rest is noise.
    task automatic send_random_request();
        bit [1:0]    kind;
        bit          level;
        bit [7:0]    offset;
        bit [63:0]   value;
        int unsigned classes;
        int unsigned nbits;
        int unsigned len;
        int unsigned start;
        kind    = 2'($urandom_range(0, 3));
        level   = 1'($urandom_range(0, 1));
        classes = shadow.effective_classes();
        if (classes != 0 && $urandom_range(0, 3) != 0) begin
            offset = 8'($urandom_range(0, classes - 1));
        end else begin
            offset = 8'($urandom_range(0, 255));
        end
        nbits = $clog2(64'(shadow.virtual_limit(level)) + 64'd1);
        value = {$urandom, $urandom};
        if (kind == cmrv_pkg::KIND_WR_MASK && nbits != 0 && $urandom_range(0, 9) < 7) begin
            len   = $urandom_range(1, nbits);
            start = $urandom_range(0, nbits - len);
            value = ((64'd1 << len) - 64'd1) << start;
        end else if (kind == cmrv_pkg::KIND_WR_CLASS && $urandom_range(0, 9) < 7) begin
            value = {32'(classes != 0 ? $urandom_range(0, classes - 1) : $urandom_range(0, 3)),
                     32'd0};
        end else if ($urandom_range(0, 1) == 0) begin
            value = value & 64'hFFFF_FFFF;
        end
        send_request(kind, level, offset, value);
    endtask

    // Result side: accept in random bursts, stall for a random stretch between them.
    initial begin
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat (($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24))
                    @(posedge aclk);
                if (!calm) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 13)) @(posedge aclk);
                end
            end
        end
    end

    // Check every accepted reply against the oldest prediction.
    always @(posedge aclk) begin
        cmrv_pkg::res_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status            = m_status;
            got.read_data         = m_read_data;
            got.phys_mask_write   = m_phys_mask_write;
            got.phys_class_update = m_phys_class_update;
            got.phys_class        = m_phys_class;
            got.phys_level        = m_phys_level;
            got.phys_bits         = m_phys_bits;
            got.phys_bit_enable   = m_phys_bit_enable;
            shadow.check_reply(got);
        end
    end

    // Watchdog: end the run when no handshake of any kind happens for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_cache_mask_register_virtualizer_core: errors");
        $finish;
    end

    initial begin
        bit [3:0] classes;
        shadow        = new();
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_kind        <= cmrv_pkg::KIND_RD_MASK;
        s_cache_level <= 1'b0;
        s_reg_offset  <= '0;
        s_write_value <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: L2 ways 11:4 give a virtual limit of 0xFF, L3 owns every way.
        configure(1'b1, 1'b1, 1'b1, 4'd8, 32'h0000_0FF0, 32'hFFFF_FFFF,
                  64'h8877_6655_4433_2211);
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b0, 8'd0, 64'h0000_00FF);
        send_request(cmrv_pkg::KIND_RD_MASK, 1'b0, 8'd0, 64'd0);
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b0, 8'd7, 64'h1);
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b0, 8'd1, 64'h100);  // past the virtual limit
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b0, 8'd1, 64'h5);    // run with a hole
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b0, 8'd1, 64'h0);    // empty mask
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b1, 8'd3, 64'hFFFF_FFFF);
        send_request(cmrv_pkg::KIND_RD_MASK, 1'b1, 8'd3, 64'd0);
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b1, 8'd2, 64'hFFFF_FFFF_0000_0001);
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b1, 8'd8, 64'h1);    // class out of range
        send_request(cmrv_pkg::KIND_RD_MASK, 1'b0, 8'd255, 64'd0);
        send_request(cmrv_pkg::KIND_RD_CLASS, 1'b0, 8'd0, 64'd0);
        send_request(cmrv_pkg::KIND_WR_CLASS, 1'b0, 8'd0, {32'd7, 32'd0});
        send_request(cmrv_pkg::KIND_RD_CLASS, 1'b1, 8'd0, 64'd0);
        send_request(cmrv_pkg::KIND_WR_CLASS, 1'b0, 8'd0, {32'd8, 32'd0});
        send_request(cmrv_pkg::KIND_WR_CLASS, 1'b0, 8'd0, {32'd0, 32'd1});
        send_request(cmrv_pkg::KIND_WR_CLASS, 1'b0, 8'd0, {32'hFFFF_FFFF, 32'd0});
        drain();

        // Class count above the limit clamps to eight; empty L2 ways deny every write;
        // L3 owns only the top way.
        configure(1'b1, 1'b1, 1'b1, 4'd15, 32'd0, 32'h8000_0000, 64'hFFEE_DDCC_BBAA_9988);
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b0, 8'd0, 64'h1);
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b1, 8'd7, 64'h1);
        send_request(cmrv_pkg::KIND_RD_MASK, 1'b1, 8'd7, 64'd0);
        send_request(cmrv_pkg::KIND_WR_MASK, 1'b1, 8'd0, 64'h3);
        send_request(cmrv_pkg::KIND_WR_CLASS, 1'b0, 8'd0, {32'd7, 32'd0});
        drain();

        // Virtualization off: everything is denied.
        configure(1'b0, 1'b1, 1'b1, 4'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
        send_request(cmrv_pkg::KIND_RD_CLASS, 1'b0, 8'd0, 64'd0);
        send_request(cmrv_pkg::KIND_RD_MASK, 1'b1, 8'd7, 64'd0);
        send_request(cmrv_pkg::KIND_WR_CLASS, 1'b0, 8'd0, 64'd0);
        drain();

        // Random phases, the first two at the extremes of the setup.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 2) begin
                calm = 1'b1;
            end
            case (p)
                0: configure(1'b1, 1'b1, 1'b1, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
                1: configure(1'b1, 1'b1, 1'b1, 4'd1, 32'h1, 32'h1, 64'd0);
                default: begin
                    case ($urandom_range(0, 5))
                        0:       classes = 4'($urandom_range(9, 15));
                        1:       classes = 4'd0;
                        default: classes = 4'($urandom_range(1, 8));
                    endcase
                    configure($urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0,
                              $urandom_range(0, 3) != 0, classes, pick_way_mask(),
                              pick_way_mask(), {$urandom, $urandom});
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_random_request();
            end
            drain();
        end

        // Let the pipeline settle before the verdict.
        repeat (8) @(posedge aclk);
        if (shadow.errors == 0) begin
            $display("tb_cache_mask_register_virtualizer_core: clean");
        end else begin
            $display("tb_cache_mask_register_virtualizer_core: errors");
        end
        $finish;
    end

endmodule

// ----- cache_mask_register_virtualizer_core.f -----
+incdir+rtl
rtl/cmrv_pkg.sv
rtl/cmrv_cfg_regs.sv
rtl/cmrv_vstore.sv
rtl/cmrv_decide.sv
rtl/cache_mask_register_virtualizer_core.sv
dv/tb_cache_mask_register_virtualizer_core.sv
